### rtl/drrip_pkg.sv
package drrip_pkg;

    localparam int SET_FIELD_W = 11;
    localparam int WAY_FIELD_W = 5;
    localparam int VMASK_W     = 16;
    localparam int VICTIM_W    = 4;
    localparam int SET_SPAN    = 2048;
    localparam int MAX_WAYS    = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_COLD = RRPV_MAX - 2'd1;
    localparam logic [1:0] RRPV_HOT  = 2'd0;

    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [SET_FIELD_W-1:0] set_index;
        logic [WAY_FIELD_W-1:0] way_index;
        logic                   is_hit;
        logic [VMASK_W-1:0]     valid_mask;
    } req_t;

    typedef struct packed {
        logic lead_s;
        logic lead_b;
        logic srrip_fill;
    } policy_t;

    typedef struct packed {
        logic row_we;
        logic sel_inc;
        logic sel_dec;
    } row_ctl_t;

endpackage

### rtl/drrip_rrpv_ram.sv
module drrip_rrpv_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/drrip_row_logic.sv
module drrip_row_logic import drrip_pkg::*; #(
    parameter int NUM_WAYS = 16
) (
    input  req_t                  req,
    input  policy_t               policy,
    input  logic [2*NUM_WAYS-1:0] row_rd,
    output logic [2*NUM_WAYS-1:0] row_wr,
    output row_ctl_t              ctl,
    output logic [VICTIM_W-1:0]   victim_way
);

    logic [MAX_WAYS-1:0]    valid_ext;
    logic                   any_invalid;
    logic [WAY_FIELD_W-1:0] first_invalid;
    logic [WAY_FIELD_W-1:0] best_way;
    logic [3:0]             has_val;
    logic [1:0]             max_val;
    logic [1:0]             age_step;
    logic [1:0]             install_val;
    logic                   way_ok;
    logic                   is_update;

    always_comb begin
        valid_ext     = {{(MAX_WAYS - VMASK_W){1'b1}}, req.valid_mask};
        any_invalid   = 1'b0;
        first_invalid = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!valid_ext[w]) begin
                any_invalid   = 1'b1;
                first_invalid = WAY_FIELD_W'(w);
            end
        end

        has_val = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            has_val[row_rd[2*w +: 2]] = 1'b1;
        end
        if (has_val[3]) begin
            max_val = 2'd3;
        end else if (has_val[2]) begin
            max_val = 2'd2;
        end else if (has_val[1]) begin
            max_val = 2'd1;
        end else begin
            max_val = 2'd0;
        end
        best_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (row_rd[2*w +: 2] == max_val) begin
                best_way = WAY_FIELD_W'(w);
            end
        end
        age_step = RRPV_MAX - max_val;
    end

    always_comb begin
        is_update = (req.func == FUNC_UPDATE);
        way_ok    = (int'(req.way_index) < NUM_WAYS);
        if (req.is_hit || policy.srrip_fill) begin
            install_val = RRPV_HOT;
        end else begin
            install_val = RRPV_COLD;
        end

        row_wr = row_rd;
        if (is_update) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (WAY_FIELD_W'(w) == req.way_index) begin
                    row_wr[2*w +: 2] = install_val;
                end
            end
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                row_wr[2*w +: 2] = row_rd[2*w +: 2] + age_step;
            end
        end

        if (is_update) begin
            ctl.row_we = way_ok;
        end else begin
            ctl.row_we = !any_invalid && (max_val != RRPV_MAX);
        end
        ctl.sel_inc = is_update && way_ok && req.is_hit && policy.lead_s;
        ctl.sel_dec = is_update && way_ok && req.is_hit && policy.lead_b;

        if (any_invalid) begin
            victim_way = first_invalid[VICTIM_W-1:0];
        end else begin
            victim_way = best_way[VICTIM_W-1:0];
        end
    end

endmodule

### rtl/drrip_replacement_policy_core.sv
// Channel | Direction | Ports                      | Contents
// s_      | in        | s_tvalid s_tready s_tdata  | one replacement request
//         |           | s_tuser                    | request kind
// m_      | out       | m_tvalid m_tready m_tdata  | victim way of a victim request
//
// Each request passes through ST_READ, which reads its set from the state memory, and
// ST_EXEC, which computes and writes the row back. A new request can be taken in the
// write-back step of the one before, so only one is in flight. A victim result shows up
// on m_ at the write-back edge, after ST_READ and ST_EXEC, and sits in an output register.
// After reset a clearing pass writes every set once while s_tready stays low. A victim
// result that is not taken holds the next victim request in its ST_EXEC step.
module drrip_replacement_policy_core import drrip_pkg::*; #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int LEADER_PERIOD = 32,
    parameter int SELECTOR_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [10:0] set_index, [15:11] way_index, [16] is_hit, [32:17] valid_mask
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] victim_way
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int ROW_W     = 2 * NUM_WAYS;
    localparam int SET_LIMIT = (NUM_SETS < SET_SPAN) ? NUM_SETS : SET_SPAN;
    localparam int SET_STEPS = $clog2((SET_SPAN + NUM_SETS - 1) / NUM_SETS);
    localparam int PH_STEPS  = $clog2((SET_LIMIT + LEADER_PERIOD - 1) / LEADER_PERIOD);
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
    localparam logic [SELECTOR_BITS-1:0] SEL_INIT = SEL_MAX >> 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [SET_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [VICTIM_W-1:0]      victim_reg, victim_next;
    req_t                     req_reg, req_next;
    logic [SET_FIELD_W-1:0]   set_red_reg, set_red_next;

    logic                   s_accept;
    logic                   exec_done;
    logic                   exec_fire;
    logic [SET_FIELD_W-1:0] set_mod;
    logic [SET_FIELD_W-1:0] phase;
    policy_t                policy;
    row_ctl_t               ctl;
    logic [ROW_W-1:0]       row_rd;
    logic [ROW_W-1:0]       row_wr;
    logic [VICTIM_W-1:0]    victim_way;
    logic                   ram_rd_en;
    logic                   ram_wr_en;
    logic [SET_W-1:0]       ram_wr_addr;
    logic [ROW_W-1:0]       ram_wr_data;

    always_comb begin
        set_mod = req_reg.set_index;
        for (int i = SET_STEPS - 1; i >= 0; i--) begin
            if (int'(set_mod) >= (NUM_SETS << i)) begin
                set_mod = set_mod - SET_FIELD_W'(NUM_SETS << i);
            end
        end
    end

    always_comb begin
        phase = set_red_reg;
        for (int i = PH_STEPS - 1; i >= 0; i--) begin
            if (int'(phase) >= (LEADER_PERIOD << i)) begin
                phase = phase - SET_FIELD_W'(LEADER_PERIOD << i);
            end
        end
        policy.lead_s     = (phase == SET_FIELD_W'(0));
        policy.lead_b     = (phase == SET_FIELD_W'(1));
        policy.srrip_fill = policy.lead_s || (!policy.lead_b && (sel_reg >= SEL_INIT));
    end

    drrip_row_logic #(
        .NUM_WAYS (NUM_WAYS)
    ) u_row_logic (
        .req        (req_reg),
        .policy     (policy),
        .row_rd     (row_rd),
        .row_wr     (row_wr),
        .ctl        (ctl),
        .victim_way (victim_way)
    );

    drrip_rrpv_ram #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_rrpv_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (SET_W'(set_mod)),
        .rd_data (row_rd),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    assign exec_done = (req_reg.func == FUNC_UPDATE) || !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == ST_EXEC) && exec_done;
    assign s_tready  = (state_reg == ST_IDLE) || exec_fire;
    assign s_accept  = s_tvalid && s_tready;
    assign ram_rd_en = (state_reg == ST_READ);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = {NUM_WAYS{RRPV_MAX}};
        end else begin
            ram_wr_en   = exec_fire && ctl.row_we;
            ram_wr_addr = SET_W'(set_red_reg);
            ram_wr_data = row_wr;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        sel_next      = sel_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        victim_next   = victim_reg;
        req_next      = req_reg;
        set_red_next  = set_red_reg;

        if (s_accept) begin
            req_next.func       = s_tuser;
            req_next.set_index  = s_tdata[10:0];
            req_next.way_index  = s_tdata[15:11];
            req_next.is_hit     = s_tdata[16];
            req_next.valid_mask = s_tdata[32:17];
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                set_red_next = set_mod;
                state_next   = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_done) begin
                    if (ctl.sel_inc && (sel_reg != SEL_MAX)) begin
                        sel_next = sel_reg + SELECTOR_BITS'(1);
                    end else if (ctl.sel_dec && (sel_reg != '0)) begin
                        sel_next = sel_reg - SELECTOR_BITS'(1);
                    end
                    if (req_reg.func == FUNC_VICTIM) begin
                        m_tvalid_next = 1'b1;
                        victim_next   = victim_way;
                    end
                    state_next = s_accept ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            sel_reg      <= SEL_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        victim_reg  <= victim_next;
        req_reg     <= req_next;
        set_red_reg <= set_red_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VICTIM_W){1'b0}}, victim_reg};

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_tready && !m_tvalid_reg))
        else $error("request taken or result shown during the clearing pass");

    a_sel_moves_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(exec_fire && (req_reg.func == FUNC_UPDATE) && req_reg.is_hit)
        |=> $stable(sel_reg))
        else $error("selector moved without a hit update");

    a_victim_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && (req_reg.func == FUNC_VICTIM)) |=> m_tvalid_reg)
        else $error("victim request finished without a result");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && (req_reg.func == FUNC_VICTIM) && m_tvalid_reg
         && !m_tready) |-> (!s_tready && !ram_wr_en))
        else $error("stalled victim request wrote state or took a new request");

endmodule
